// File: sv/shpp_pkg.sv
// ----------------------------------------------------------------------------
// shpp_pkg
// shared types and constants of the sync-header packet parser
// ----------------------------------------------------------------------------
package shpp_pkg;

   localparam int MAX_WORDS_DEF = 15;

   localparam logic [7:0]  CH_S    = 8'h73;   // 's'
   localparam logic [7:0]  CH_N    = 8'h6E;   // 'n'
   localparam logic [7:0]  CH_P    = 8'h70;   // 'p'
   localparam logic [15:0] HDR_SUM = 16'h0151; // 's' + 'n' + 'p'
   localparam logic [7:0]  MIN_LEN = 8'd7;

   typedef enum logic [2:0] {
      PH_SEARCH = 3'd0,
      PH_TYPE   = 3'd1,
      PH_ADDR   = 3'd2,
      PH_DATA   = 3'd3,
      PH_CKH    = 3'd4,
      PH_CKL    = 3'd5,
      PH_DONE   = 3'd6
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_SHORT      = 3'd1,
      ST_NO_HEADER  = 3'd2,
      ST_NO_ROOM    = 3'd3,
      ST_INCOMPLETE = 3'd4,
      ST_BAD_SUM    = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      CS_IN   = 2'd0,
      CS_RD   = 2'd1,
      CS_SEND = 2'd2
   } ctl_state_type;

   typedef struct packed {
      logic       take;      // byte accepted this cycle
      phase_type  phase;     // parse phase the byte belongs to
      logic       clear;     // end of buffer, clear parse state
      logic       load_pkt;  // checksum complete, latch packet result
      logic       load_err;  // end of buffer without packet, latch error
      status_type err_code;
      logic       rd_word;   // read word memory at the output index
      logic       next_word; // advance output index
   } dp_cmd_type;

   typedef struct packed {
      logic hdr_hit;
      logic data_last;
      logic seen_zero;
      logic target_zero;
      logic count_short;
      logic last_word;
   } dp_stat_type;

endpackage

// File: sv/shpp_dp.sv
// ----------------------------------------------------------------------------
// shpp_dp
// parser datapath: header shift, counters, checksum, word memory, results
// ----------------------------------------------------------------------------
module shpp_dp import shpp_pkg::*; #(
   parameter int MAX_WORDS = MAX_WORDS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [7:0]  rx_byte,
   input  dp_cmd_type  cmd,
   output dp_stat_type stat,
   output status_type  status,
   output logic [7:0]  reg_address,
   output logic [7:0]  type_byte,
   output logic [3:0]  word_count,
   output logic [3:0]  word_index,
   output logic [31:0] data_word,
   output logic        word_valid,
   output logic [15:0] sum_value
);

   localparam int         AW     = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
   localparam logic [3:0] MAX_W4 = 4'(MAX_WORDS);

   logic [15:0] prev_ff, prev_in;
   logic [7:0]  count_ff, count_in, count_inc;
   logic [5:0]  target_ff, target_in;
   logic [5:0]  seen_ff, seen_in;
   logic [7:0]  type_ff, type_in;
   logic [7:0]  addr_ff, addr_in;
   logic [15:0] sum_ff, sum_in, sum_add;
   logic [7:0]  ckh_ff, ckh_in;
   logic [23:0] asm_ff, asm_in;

   status_type  res_status_ff, res_status_in;
   logic [7:0]  res_addr_ff, res_addr_in;
   logic [7:0]  res_type_ff, res_type_in;
   logic [3:0]  res_count_ff, res_count_in;
   logic [15:0] res_sum_ff, res_sum_in;
   logic [3:0]  idx_ff, idx_in;
   logic [31:0] mem_q_ff;

   logic [31:0] word_mem [MAX_WORDS];
   logic [3:0]  wr_word;
   logic        mem_we;
   logic [3:0]  pkt_count;

   assign count_inc = (count_ff == 8'hFF) ? count_ff : count_ff + 8'd1;
   assign sum_add   = sum_ff + {8'h00, rx_byte};
   assign wr_word   = seen_ff[5:2];
   assign mem_we    = cmd.take && (cmd.phase == PH_DATA) && (seen_ff[1:0] == 2'd3)
                      && (wr_word < MAX_W4);
   assign pkt_count = (target_ff[5:2] > MAX_W4) ? MAX_W4 : target_ff[5:2];

   always_comb begin
      stat.hdr_hit     = (prev_ff == {CH_S, CH_N}) && (rx_byte == CH_P);
      stat.data_last   = ({1'b0, seen_ff} + 7'd1) >= {1'b0, target_ff};
      stat.seen_zero   = (seen_ff == 6'd0);
      stat.target_zero = (target_ff == 6'd0);
      stat.count_short = (count_inc < MIN_LEN);
      stat.last_word   = (res_count_ff == 4'd0)
                         || (({1'b0, idx_ff} + 5'd1) == {1'b0, res_count_ff});
   end

   // parse state
   always_comb begin
      prev_in   = prev_ff;
      count_in  = count_ff;
      target_in = target_ff;
      seen_in   = seen_ff;
      type_in   = type_ff;
      addr_in   = addr_ff;
      sum_in    = sum_ff;
      ckh_in    = ckh_ff;
      asm_in    = asm_ff;
      if (cmd.take) begin
         count_in = count_inc;
         unique case (cmd.phase)
            PH_SEARCH: begin
               if (stat.hdr_hit) sum_in = HDR_SUM;
               prev_in = {prev_ff[7:0], rx_byte};
            end
            PH_TYPE: begin
               type_in   = rx_byte;
               target_in = rx_byte[7] ? (rx_byte[6] ? {rx_byte[5:2], 2'b00} : 6'd4) : 6'd0;
               seen_in   = 6'd0;
               sum_in    = sum_add;
            end
            PH_ADDR: begin
               addr_in = rx_byte;
               sum_in  = sum_add;
            end
            PH_DATA: begin
               asm_in  = {asm_ff[15:0], rx_byte};
               sum_in  = sum_add;
               seen_in = seen_ff + 6'd1;
            end
            PH_CKH: begin
               ckh_in = rx_byte;
            end
            default: ;
         endcase
         if (cmd.clear) begin
            prev_in   = 16'h0000;
            count_in  = 8'h00;
            target_in = 6'd0;
            seen_in   = 6'd0;
            type_in   = 8'h00;
            addr_in   = 8'h00;
            sum_in    = 16'h0000;
            ckh_in    = 8'h00;
         end
      end
   end

   // result registers and output index
   always_comb begin
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      res_type_in   = res_type_ff;
      res_count_in  = res_count_ff;
      res_sum_in    = res_sum_ff;
      idx_in        = idx_ff;
      if (cmd.load_pkt) begin
         res_status_in = ({ckh_ff, rx_byte} == sum_ff) ? ST_OK : ST_BAD_SUM;
         res_addr_in   = addr_ff;
         res_type_in   = type_ff;
         res_count_in  = pkt_count;
         res_sum_in    = sum_ff;
         idx_in        = 4'd0;
      end else if (cmd.load_err) begin
         res_status_in = cmd.err_code;
         res_addr_in   = 8'h00;
         res_type_in   = 8'h00;
         res_count_in  = 4'd0;
         res_sum_in    = 16'h0000;
         idx_in        = 4'd0;
      end else if (cmd.next_word) begin
         idx_in = idx_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff   <= 16'h0000;
         count_ff  <= 8'h00;
         target_ff <= 6'd0;
         seen_ff   <= 6'd0;
         type_ff   <= 8'h00;
         addr_ff   <= 8'h00;
         sum_ff    <= 16'h0000;
         ckh_ff    <= 8'h00;
      end else begin
         prev_ff   <= prev_in;
         count_ff  <= count_in;
         target_ff <= target_in;
         seen_ff   <= seen_in;
         type_ff   <= type_in;
         addr_ff   <= addr_in;
         sum_ff    <= sum_in;
         ckh_ff    <= ckh_in;
      end
   end

   always_ff @(posedge clock) begin
      asm_ff        <= asm_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      res_type_ff   <= res_type_in;
      res_count_ff  <= res_count_in;
      res_sum_ff    <= res_sum_in;
      idx_ff        <= idx_in;
   end

   // word memory, one write port for assembly, registered read for output
   always_ff @(posedge clock) begin
      if (mem_we) word_mem[wr_word[AW-1:0]] <= {asm_ff, rx_byte};
      if (cmd.rd_word) mem_q_ff <= word_mem[idx_ff[AW-1:0]];
   end

   assign status      = res_status_ff;
   assign reg_address = res_addr_ff;
   assign type_byte   = res_type_ff;
   assign word_count  = res_count_ff;
   assign word_index  = idx_ff;
   assign word_valid  = (res_count_ff != 4'd0);
   assign data_word   = word_valid ? mem_q_ff : 32'h0000_0000;
   assign sum_value   = res_sum_ff;

endmodule

// File: sv/shpp_ctrl.sv
// ----------------------------------------------------------------------------
// shpp_ctrl
// parser controller: parse phase, end-of-buffer status and result sequencing
// ----------------------------------------------------------------------------
module shpp_ctrl import shpp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tlast,
   output logic        req_tready,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   ctl_state_type state_ff, state_in;
   phase_type     phase_ff, phase_in, phase_nx;
   status_type    end_code;
   logic          take;
   logic          give;
   logic          load_pkt;
   logic          load_err;

   assign take = req_tvalid && (state_ff == CS_IN);
   assign give = rsp_tready && (state_ff == CS_SEND);

   // parse phase after this byte, before the end-of-buffer clear
   always_comb begin
      unique case (phase_ff)
         PH_SEARCH: phase_nx = stat.hdr_hit ? PH_TYPE : PH_SEARCH;
         PH_TYPE:   phase_nx = PH_ADDR;
         PH_ADDR:   phase_nx = stat.target_zero ? PH_CKH : PH_DATA;
         PH_DATA:   phase_nx = stat.data_last ? PH_CKH : PH_DATA;
         PH_CKH:    phase_nx = PH_CKL;
         default:   phase_nx = PH_DONE;
      endcase
   end

   // why a buffer ended without a packet
   always_comb begin
      if (stat.count_short) begin
         end_code = ST_SHORT;
      end else begin
         unique case (phase_nx) inside
            PH_SEARCH:      end_code = ST_NO_HEADER;
            PH_TYPE, PH_ADDR: end_code = ST_NO_ROOM;
            PH_DATA:        end_code = stat.seen_zero ? ST_NO_ROOM : ST_INCOMPLETE;
            PH_CKH, PH_CKL: end_code = stat.target_zero ? ST_NO_ROOM : ST_INCOMPLETE;
            default:        end_code = ST_INCOMPLETE;
         endcase
      end
   end

   assign load_pkt = take && (phase_ff == PH_CKL);
   assign load_err = take && req_tlast && !load_pkt && (phase_nx != PH_DONE);

   // next state
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      if (take) phase_in = req_tlast ? PH_SEARCH : phase_nx;
      unique case (state_ff)
         CS_IN:   if (load_pkt || load_err) state_in = CS_RD;
         CS_RD:   state_in = CS_SEND;
         CS_SEND: if (give) state_in = stat.last_word ? CS_IN : CS_RD;
         default: state_in = CS_IN;
      endcase
   end

   // outputs
   always_comb begin
      req_tready    = (state_ff == CS_IN);
      rsp_tvalid    = (state_ff == CS_SEND);
      cmd.take      = take;
      cmd.phase     = phase_ff;
      cmd.clear     = take && req_tlast;
      cmd.load_pkt  = load_pkt;
      cmd.load_err  = load_err;
      cmd.err_code  = end_code;
      cmd.rd_word   = (state_ff == CS_RD);
      cmd.next_word = give && !stat.last_word;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IN;
         phase_ff <= PH_SEARCH;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request taken while a result is pending");

   a_eob_clears: assert property (@(posedge clock) disable iff (reset)
      (take && req_tlast) |=> (phase_ff == PH_SEARCH))
      else $error("parse phase not cleared at end of buffer");

   a_pkt_emits: assert property (@(posedge clock) disable iff (reset)
      (take && (phase_ff == PH_CKL)) |=> (state_ff == CS_RD))
      else $error("completed packet did not start result output");

   a_reset_state: assert property (@(posedge clock)
      reset |=> ((state_ff == CS_IN) && (phase_ff == PH_SEARCH)))
      else $error("controller not idle after reset");

endmodule

// File: sv/sync_header_packet_parser.sv
// ----------------------------------------------------------------------------
// sync_header_packet_parser
// byte-stream parser for 'snp' headed packets with a 16-bit sum checksum
// ----------------------------------------------------------------------------
// usage:
//   req channel carries one buffer byte per request, req_tlast on the
//   buffer's last byte. the parser hunts for the 's','n','p' header, then
//   takes type, address, 0/4/4*n data bytes and a big-endian checksum.
//   rsp channel returns the packet as one result per data word (or a single
//   result when there is no data), rsp_tlast on the final one. a buffer that
//   ends without a complete packet gives one error result instead.
// sequencing:
//   req_tready stays high until a result is due, then drops; each result is
//   first read from the word memory, then presented until the receiver takes
//   it, and the single read port means the next word is not read before the
//   current result is taken. a packet returns up to fifteen words.
// reset and stall:
//   reset returns the parser to header search with a cleared byte count.
//   while rsp_tready is low the current result holds and no request is taken.
// ----------------------------------------------------------------------------
module sync_header_packet_parser import shpp_pkg::*; #(
   parameter int MAX_WORDS = MAX_WORDS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // rx_byte[7:0]
   input  logic        req_tlast,   // end_of_buffer
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // status[2:0], reg_address[10:3], type_byte[18:11],
                                    // word_count[22:19], word_index[26:23],
                                    // data_word[58:27], word_valid[59],
                                    // sum_value[75:60], zero pad[79:76]
   output logic        rsp_tlast    // last_result
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   status_type  status;
   logic [7:0]  reg_address;
   logic [7:0]  type_byte;
   logic [3:0]  word_count;
   logic [3:0]  word_index;
   logic [31:0] data_word;
   logic        word_valid;
   logic [15:0] sum_value;

   // phase tracking, error classification and result sequencing
   shpp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // counters, checksum, word store and result registers
   shpp_dp #(
      .MAX_WORDS (MAX_WORDS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .rx_byte     (req_tdata),
      .cmd         (cmd),
      .stat        (stat),
      .status      (status),
      .reg_address (reg_address),
      .type_byte   (type_byte),
      .word_count  (word_count),
      .word_index  (word_index),
      .data_word   (data_word),
      .word_valid  (word_valid),
      .sum_value   (sum_value)
   );

   // result fields packed low to high
   assign rsp_tdata = {4'h0, sum_value, word_valid, data_word, word_index, word_count,
                       type_byte, reg_address, status};

   // last word of a packet, or the lone result of a wordless packet or error
   assign rsp_tlast = stat.last_word;

endmodule
